>>> sv/sfmt_pkg.sv
// Shared types and constants for the scoreboard frame Manchester transmitter.
// Used by every module of the block; depends on nothing else.
package sfmt_pkg;

    // Operation codes carried in the input transaction.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_REPEATS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_PAIRS = 1'b1;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [3:0] BLOCK_REPEATS_RST  = 4'd10;
    localparam logic [4:0] PREAMBLE_PAIRS_RST = 5'd19;

    // Block layout in half-bit slots.
    localparam logic [6:0] SYNC_SLOTS  = 7'd3;
    localparam logic [6:0] DATA_END    = 7'd67;
    localparam logic [6:0] BLOCK_SLOTS = 7'd70;

    // Nibble codes of the frame word.
    localparam logic [3:0] NIB_BLANK = 4'hF;
    localparam logic [3:0] MARK_3    = 4'h3;
    localparam logic [3:0] MARK_2    = 4'h2;
    localparam logic [3:0] MARK_1    = 4'h1;
    localparam logic [3:0] MARK_0    = 4'h0;

    typedef struct packed {
        logic       operation;
        logic [3:0] field_number;
        logic [9:0] display_value;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic sending;
        logic final_slot;
    } t_out_item;

    // Registered input transaction with the two digit quotients already formed.
    typedef struct packed {
        t_in_item   item;
        logic [6:0] div10;
        logic [3:0] div100;
    } t_pre_item;

endpackage

>>> sv/sfmt_in_stage.sv
// Input register of the transmitter: captures a transaction and forms value/10
// and value/100 by reciprocal multiplication. Depends on sfmt_pkg.
module sfmt_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sfmt_pkg::t_in_item    i_in_data,
    output logic                  o_pre_valid,
    input  logic                  i_pre_ready,
    output sfmt_pkg::t_pre_item   o_pre_data
);

    logic                r_valid;
    sfmt_pkg::t_pre_item r_pre;
    logic                n_valid;
    logic                accept;
    logic [17:0]         prod10;
    logic [15:0]         prod100;

    // 205/2048 and 41/4096 give exact quotients for every 10-bit value.
    assign prod10  = 18'(i_in_data.display_value) * 18'd205;
    assign prod100 = 16'(i_in_data.display_value) * 16'd41;

    assign o_in_stall  = r_valid && !i_pre_ready;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_pre_valid = r_valid;
    assign o_pre_data  = r_pre;

    always_comb begin
        n_valid = accept || (r_valid && !i_pre_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pre.item   <= i_in_data;
            r_pre.div10  <= prod10[17:11];
            r_pre.div100 <= prod100[15:12];
        end
    end

endmodule

>>> sv/sfmt_seq.sv
// Frame sequencer: builds the digit word on a start, steps the preamble and
// block counters on each tick, and holds the result register. Depends on sfmt_pkg.
module sfmt_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [3:0]            i_block_repeats,
    input  logic [4:0]            i_preamble_pairs,
    input  logic                  i_pre_valid,
    output logic                  o_pre_ready,
    input  sfmt_pkg::t_pre_item   i_pre_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sfmt_pkg::t_out_item   o_out_data
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PREAMBLE = 2'd1;
    localparam logic [1:0] PH_BLOCK    = 2'd2;

    logic [1:0]          r_phase, n_phase;
    logic [6:0]          r_slot, n_slot;
    logic [3:0]          r_block, n_block;
    logic [31:0]         r_word, n_word;
    logic                r_out_valid, n_out_valid;
    sfmt_pkg::t_out_item r_out, n_out;

    logic        advance;
    logic [3:0]  hundreds, tens, units;
    logic [9:0]  tens_x10;
    logic [6:0]  hund_x10;
    logic [4:0]  pairs_eff;
    logic [3:0]  reps_eff;
    logic [5:0]  data_k;
    logic        data_bit;
    logic        blk_level;
    logic        last_block;

    assign o_pre_ready = !r_out_valid || !i_out_stall;
    assign advance     = i_pre_valid && o_pre_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Digit split from the two registered quotients.
    always_comb begin
        tens_x10 = 10'(i_pre_data.div10) * 10'd10;
        hund_x10 = 7'(i_pre_data.div100) * 7'd10;
        units    = 4'(i_pre_data.item.display_value - tens_x10);
        tens     = 4'(i_pre_data.div10 - hund_x10);
        hundreds = (i_pre_data.div100 == 4'd10) ? 4'd0 : i_pre_data.div100;
        if (i_pre_data.item.display_value < 10'd100) begin
            hundreds = sfmt_pkg::NIB_BLANK;
        end
        if (i_pre_data.item.display_value < 10'd10) begin
            tens = sfmt_pkg::NIB_BLANK;
        end
    end

    // Level of the current block slot: mark sync, Manchester data, space postamble.
    always_comb begin
        data_k   = 6'(r_slot - sfmt_pkg::SYNC_SLOTS);
        data_bit = r_word[5'd31 - data_k[5:1]];
        if (r_slot < sfmt_pkg::SYNC_SLOTS) begin
            blk_level = 1'b1;
        end else if (r_slot >= sfmt_pkg::DATA_END) begin
            blk_level = 1'b0;
        end else begin
            blk_level = ~(data_bit ^ data_k[0]);
        end
    end

    always_comb begin
        pairs_eff  = (i_preamble_pairs == 5'd0) ? 5'd1 : i_preamble_pairs;
        reps_eff   = (i_block_repeats == 4'd0) ? 4'd1 : i_block_repeats;
        last_block = ({1'b0, r_block} + 5'd1) >= {1'b0, reps_eff};

        n_phase     = r_phase;
        n_slot      = r_slot;
        n_block     = r_block;
        n_word      = r_word;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (advance) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (i_pre_data.item.operation == sfmt_pkg::OP_START) begin
                if (r_phase == PH_IDLE) begin
                    n_word  = {sfmt_pkg::MARK_3, i_pre_data.item.field_number,
                               sfmt_pkg::MARK_2, hundreds,
                               sfmt_pkg::MARK_1, tens,
                               sfmt_pkg::MARK_0, units};
                    n_phase = PH_PREAMBLE;
                    n_slot  = 7'd0;
                    n_block = 4'd0;
                end
            end else begin
                unique case (r_phase)
                    PH_PREAMBLE: begin
                        n_out.line_level = ~r_slot[0];
                        n_out.sending    = 1'b1;
                        if (({1'b0, r_slot} + 8'd1) >= {2'b0, pairs_eff, 1'b0}) begin
                            n_phase = PH_BLOCK;
                            n_slot  = 7'd0;
                        end else begin
                            n_slot = r_slot + 7'd1;
                        end
                    end
                    PH_BLOCK: begin
                        n_out.line_level = blk_level;
                        n_out.sending    = 1'b1;
                        if (({1'b0, r_slot} + 8'd1) >= {1'b0, sfmt_pkg::BLOCK_SLOTS}) begin
                            n_slot = 7'd0;
                            if (last_block) begin
                                n_out.final_slot = 1'b1;
                                n_phase          = PH_IDLE;
                                n_block          = 4'd0;
                            end else begin
                                n_block = r_block + 4'd1;
                            end
                        end else begin
                            n_slot = r_slot + 7'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_slot      <= 7'd0;
            r_block     <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_block     <= n_block;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_out  <= n_out;
    end

    a_final_is_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.final_slot |-> r_out.sending)
        else $error("final slot flagged on a result that sends nothing");

    a_final_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_out.final_slot |=> r_phase == PH_IDLE)
        else $error("sequencer still busy after the final slot");

    a_block_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BLOCK |-> r_slot < sfmt_pkg::BLOCK_SLOTS)
        else $error("block slot counter beyond the block length");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_IDLE |=> !r_out.sending && !r_out.line_level)
        else $error("idle transmitter drove a slot");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_IDLE
            && i_pre_data.item.operation == sfmt_pkg::OP_START
        |=> r_phase == PH_PREAMBLE && r_slot == 7'd0)
        else $error("start transaction did not open the preamble");

endmodule

>>> sv/scoreboard_frame_manchester_tx.sv
// Top level of the scoreboard frame Manchester transmitter: configuration
// registers and the two pipeline stages. Depends on sfmt_pkg, sfmt_in_stage, sfmt_seq.
//
//  Channel   Direction  Handshake            Payload
//  in        input      i_in_valid/o_in_stall   sfmt_pkg::t_in_item
//  out       output     o_out_valid/i_out_stall sfmt_pkg::t_out_item
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction per cycle is taken while o_in_stall is low. Its result passes through
// the input register and then the result register before it leaves the block.
// While a result waits on a stall, the input register takes one more transaction and
// then stalls the input; the stall reaches o_in_stall combinationally in that cycle.
// Synchronous active-low reset empties both stages, idles the sequencer and sets
// block_repeats to 10 and preamble_pairs to 19. Configuration is always ready.
module scoreboard_frame_manchester_tx (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sfmt_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sfmt_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfmt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfmt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [3:0]          r_block_repeats;
    logic [4:0]          r_preamble_pairs;
    logic                pre_valid;
    logic                pre_ready;
    sfmt_pkg::t_pre_item pre_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_repeats  <= sfmt_pkg::BLOCK_REPEATS_RST;
            r_preamble_pairs <= sfmt_pkg::PREAMBLE_PAIRS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sfmt_pkg::CFG_BLOCK_REPEATS: begin
                    r_block_repeats <= i_cfg_data[3:0];
                end
                sfmt_pkg::CFG_PREAMBLE_PAIRS: begin
                    r_preamble_pairs <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    sfmt_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_pre_valid (pre_valid),
        .i_pre_ready (pre_ready),
        .o_pre_data  (pre_data)
    );

    sfmt_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_block_repeats  (r_block_repeats),
        .i_preamble_pairs (r_preamble_pairs),
        .i_pre_valid      (pre_valid),
        .o_pre_ready      (pre_ready),
        .i_pre_data       (pre_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_data       (o_out_data)
    );

endmodule
